// File: design/scr_pkg.sv
// ----------------------------------------------------------------------------
// Spectrum column renderer package
// Widths, constants, register indexes and shared types of the renderer.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int BANDS_DEF       = 32;
    localparam int MAX_COLUMNS_DEF = 64;

    localparam int OP_W        = 1;
    localparam int BAND_IDX_W  = 5;
    localparam int LEVEL_W     = 7;
    localparam int ELAPSED_W   = 16;
    localparam int COL_IDX_W   = 6;
    localparam int UNITS_W     = 9;
    localparam int COLS_W      = 7;
    localparam int ROWS_W      = 6;
    localparam int DEN_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam int MAC_W       = 13;
    localparam int NUM_W       = MAC_W + 1;
    localparam int QUOT_W      = 7;
    localparam int DIVISOR_W   = DEN_W + 1;
    localparam int DECAY_W     = 10;
    localparam int DREM_W      = 7;
    localparam int SUB_W       = 13;
    localparam int SCALE_W     = 15;
    localparam int SETUP_CNT_W = $clog2(ELAPSED_W);

    localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OP_W-1:0] OP_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd1;

    localparam logic [COLS_W-1:0]    COLS_RESET   = 7'd64;
    localparam logic [ROWS_W-1:0]    ROWS_RESET   = 6'd8;
    localparam logic [COLS_W-1:0]    MIN_COLUMNS  = 7'd12;
    localparam logic [ROWS_W-1:0]    MIN_ROWS     = 6'd2;
    localparam logic [ROWS_W-1:0]    MAX_ROWS     = 6'd32;
    localparam logic [LEVEL_W-1:0]   FULL_LEVEL   = 7'd100;
    localparam logic [LEVEL_W-1:0]   ACTIVE_FLOOR = 7'd3;
    localparam logic [DREM_W:0]      DECAY_PERIOD = 8'd90;
    localparam logic [ELAPSED_W-1:0] ACTIVE_LIMIT = 16'd250;
    localparam logic [SUB_W-1:0]     DECAY_STEP   = 13'd7;
    localparam logic [SCALE_W-1:0]   ROUND_UP     = 15'd99;

    // floor(x / 90) = (x * 46604) >> 22 for every 16-bit x
    localparam logic [ELAPSED_W-1:0] DECAY_RECIP  = 16'd46604;
    localparam int                   DECAY_SHIFT  = 22;

    // floor(x / 100) = (x * 20972) >> 21 for every x below 43690
    localparam logic [SCALE_W-1:0]   RECIP        = 15'd20972;
    localparam int                   RECIP_SHIFT  = 21;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: design/scr_if.sv
// ----------------------------------------------------------------------------
// Spectrum column renderer channels
// Valid/ready channels for input items and for column results.
// ----------------------------------------------------------------------------
interface scr_item_if
    import scr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [BAND_IDX_W-1:0] band_index;
    logic [LEVEL_W-1:0]    band_level;
    logic [ELAPSED_W-1:0]  elapsed_ms;
    logic                  playing;

    modport source (
        output valid, operation, band_index, band_level, elapsed_ms, playing,
        input  ready
    );

    modport sink (
        input  valid, operation, band_index, band_level, elapsed_ms, playing,
        output ready
    );
endinterface

interface scr_column_if
    import scr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COL_IDX_W-1:0] column_index;
    logic [UNITS_W-1:0]   bar_units;
    logic                 last_column;

    modport source (
        output valid, column_index, bar_units, last_column,
        input  ready
    );

    modport sink (
        input  valid, column_index, bar_units, last_column,
        output ready
    );
endinterface

// File: design/scr_band_store.sv
// ----------------------------------------------------------------------------
// Band level store
// One write port, two registered read ports; entries read zero until written.
// ----------------------------------------------------------------------------
module scr_band_store
    import scr_pkg::*;
#(
    parameter int BANDS = BANDS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [$clog2(BANDS)-1:0]   waddr,
    input  logic [LEVEL_W-1:0]         wdata,
    input  logic [$clog2(BANDS)-1:0]   raddr_a,
    input  logic [$clog2(BANDS)-1:0]   raddr_b,
    output logic [LEVEL_W-1:0]         rdata_a,
    output logic [LEVEL_W-1:0]         rdata_b
);

    logic [LEVEL_W-1:0] mem [BANDS];
    logic [BANDS-1:0]   valid_reg;
    logic [LEVEL_W-1:0] rdata_a_reg;
    logic [LEVEL_W-1:0] rdata_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= valid_reg[raddr_a] ? mem[raddr_a] : '0;
        rdata_b_reg <= valid_reg[raddr_b] ? mem[raddr_b] : '0;
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: design/scr_raw_store.sv
// ----------------------------------------------------------------------------
// Raw height store
// Unsmoothed column heights of the current frame, registered read.
// ----------------------------------------------------------------------------
module scr_raw_store
    import scr_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(MAX_COLUMNS)-1:0]   waddr,
    input  logic [UNITS_W-1:0]               wdata,
    input  logic [$clog2(MAX_COLUMNS)-1:0]   raddr,
    output logic [UNITS_W-1:0]               rdata
);

    logic [UNITS_W-1:0] mem [MAX_COLUMNS];
    logic [UNITS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/scr_blend_div.sv
// ----------------------------------------------------------------------------
// Blend divider
// Restoring divider, one quotient bit per cycle, quotient below 128.
// ----------------------------------------------------------------------------
module scr_blend_div
    import scr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     numer,
    input  logic [DIVISOR_W-1:0] divisor,
    output div_stat_t            stat,
    output logic [QUOT_W-1:0]    quot
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [NUM_W-1:0]     rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [NUM_W-1:0]     trial;
    logic                 fits;

    assign trial = NUM_W'(divisor) << step_reg;
    assign fits  = rem_reg >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUOT_W - 1);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// File: design/spectrum_column_renderer_core.sv
// ----------------------------------------------------------------------------
// Spectrum column renderer
// Interpolates band levels to display columns, decays, scales and smooths.
// ----------------------------------------------------------------------------
// A load word writes one band level. A render word runs the setup steps
// (bit-serial divide for the band step; the staleness decay comes from a
// reciprocal multiply) and a preparation step, then per column the read,
// multiply-accumulate, divide and scale states, dominated by the
// one-bit-per-cycle blend divider, then a start state for the smoothing
// pass and per column the read, capture and output states of that pass over
// the raw height store (single read port); output waits on column stalls.
// Input is taken only between items; a render with fewer than 12 columns
// or 2 rows gives no columns.
module spectrum_column_renderer_core
    import scr_pkg::*;
#(
    parameter int BANDS       = BANDS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    scr_item_if.sink              item,
    scr_column_if.source          column,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BAW = $clog2(BANDS);
    localparam int CAW = $clog2(MAX_COLUMNS);

    localparam logic [ELAPSED_W-1:0] BAND_SPAN = ELAPSED_W'(BANDS - 1);
    localparam logic [BAW-1:0]       LAST_BAND = BAW'(BANDS - 1);
    localparam logic [COLS_W-1:0]    COLS_CAP  = COLS_W'(MAX_COLUMNS);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_MAC   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_SCALE = 4'd6;
    localparam logic [3:0] ST_SPRE  = 4'd7;
    localparam logic [3:0] ST_SRD   = 4'd8;
    localparam logic [3:0] ST_SCAP  = 4'd9;
    localparam logic [3:0] ST_SOUT  = 4'd10;

    logic [COLS_W-1:0]      col_cfg_reg;
    logic [ROWS_W-1:0]      row_cfg_reg;
    logic [3:0]             state_reg;
    logic [3:0]             state_next;

    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic                   active_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [CAW-1:0]         last_col_reg;
    logic [ROWS_W-1:0]      rows_reg;
    logic [SETUP_CNT_W-1:0] setup_cnt_reg;
    logic [DECAY_W-1:0]     decay_reg;
    logic [DEN_W-1:0]       rem_b_reg;
    logic [BAW-1:0]         quot_b_reg;
    logic [SUB_W-1:0]       sub_reg;
    logic [CAW-1:0]         col_reg;
    logic [BAW-1:0]         left_reg;
    logic [DEN_W-1:0]       r_reg;
    logic [SCALE_W-1:0]     p_reg;
    logic [UNITS_W-1:0]     win_a_reg;
    logic [UNITS_W-1:0]     win_b_reg;
    logic [UNITS_W-1:0]     win_c_reg;

    logic                   out_valid_reg;
    logic [COL_IDX_W-1:0]   out_col_reg;
    logic [UNITS_W-1:0]     out_units_reg;
    logic                   out_last_reg;

    logic                   item_fire;
    logic                   render_ok;
    logic [COLS_W-1:0]      w_eff;
    logic [COLS_W-1:0]      w_m1;
    logic [ROWS_W-1:0]      rows_eff;
    logic                   active_in;

    logic                   band_we;
    logic [BAW-1:0]         band_waddr;
    logic [LEVEL_W-1:0]     band_wdata;
    logic [BAW-1:0]         right_addr;
    logic [LEVEL_W-1:0]     level_l;
    logic [LEVEL_W-1:0]     level_r;

    logic [2*ELAPSED_W-1:0] decay_prod;
    logic [DEN_W:0]         sh_b;
    logic                   ge_b;

    logic [DEN_W-1:0]       weight_l;
    logic [MAC_W-1:0]       mac_sum;
    logic [NUM_W-1:0]       numer;
    div_stat_t              div_stat;
    logic [QUOT_W-1:0]      blend;

    logic [LEVEL_W-1:0]     level_dec;
    logic [LEVEL_W-1:0]     level;
    logic [SCALE_W-1:0]     p_next;
    logic [2*SCALE_W-1:0]   scale_prod;
    logic [UNITS_W-1:0]     raw_units;

    logic [DEN_W:0]         r_sum;
    logic                   r_wrap;
    logic                   col_last;

    logic [CAW-1:0]         raw_raddr;
    logic [UNITS_W-1:0]     raw_rdata;
    logic [UNITS_W+1:0]     smooth_sum;
    logic                   out_free;
    logic                   out_load;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cfg_reg <= COLS_RESET;
            row_cfg_reg <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMN_COUNT: col_cfg_reg <= cfg_data;
                REG_ROW_COUNT:    row_cfg_reg <= cfg_data[ROWS_W-1:0];
                default:          ;
            endcase
        end
    end

    // ----------------------------------------------------------------- input
    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;

    assign render_ok = (col_cfg_reg >= MIN_COLUMNS) && (row_cfg_reg >= MIN_ROWS);
    assign w_eff     = (col_cfg_reg > COLS_CAP) ? COLS_CAP : col_cfg_reg;
    assign w_m1      = w_eff - 1'b1;
    assign rows_eff  = (row_cfg_reg > MAX_ROWS) ? MAX_ROWS : row_cfg_reg;
    assign active_in = (item.elapsed_ms != '0) && (item.elapsed_ms < ACTIVE_LIMIT)
                       && item.playing;

    assign band_we    = item_fire && (item.operation == OP_LOAD)
                        && (int'(item.band_index) < BANDS);
    assign band_waddr = BAW'(item.band_index);
    assign band_wdata = (item.band_level > FULL_LEVEL) ? FULL_LEVEL : item.band_level;

    assign right_addr = (left_reg == LAST_BAND) ? left_reg : left_reg + 1'b1;

    scr_band_store #(
        .BANDS (BANDS)
    ) u_band_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (band_we),
        .waddr   (band_waddr),
        .wdata   (band_wdata),
        .raddr_a (left_reg),
        .raddr_b (right_addr),
        .rdata_a (level_l),
        .rdata_b (level_r)
    );

    // ----------------------------------------------------------------- setup
    assign decay_prod = (2*ELAPSED_W)'(elapsed_reg) * (2*ELAPSED_W)'(DECAY_RECIP);
    assign sh_b = {rem_b_reg, BAND_SPAN[setup_cnt_reg]};
    assign ge_b = sh_b >= {1'b0, den_reg};

    // ----------------------------------------------------------------- blend
    assign weight_l = den_reg - r_reg;
    assign mac_sum  = (MAC_W'(level_l) * MAC_W'(weight_l))
                      + (MAC_W'(level_r) * MAC_W'(r_reg));
    assign numer    = {mac_sum, 1'b0} + NUM_W'(den_reg);

    scr_blend_div u_blend_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_MAC),
        .numer   (numer),
        .divisor ({den_reg, 1'b0}),
        .stat    (div_stat),
        .quot    (blend)
    );

    assign level_dec = (SUB_W'(blend) > sub_reg) ? LEVEL_W'(SUB_W'(blend) - sub_reg) : '0;
    assign level     = (active_reg && (level_dec != '0) && (level_dec < ACTIVE_FLOOR))
                       ? ACTIVE_FLOOR : level_dec;
    assign p_next    = ((SCALE_W'(level) * SCALE_W'(rows_reg)) << 3) + ROUND_UP;

    assign scale_prod = (2*SCALE_W)'(p_reg) * (2*SCALE_W)'(RECIP);
    assign raw_units  = scale_prod[RECIP_SHIFT +: UNITS_W];

    assign r_sum    = {1'b0, r_reg} + {1'b0, rem_b_reg};
    assign r_wrap   = r_sum >= {1'b0, den_reg};
    assign col_last = (col_reg == last_col_reg);

    // ------------------------------------------------------------- smoothing
    assign raw_raddr = (state_reg == ST_SPRE) ? '0
                     : (col_last ? col_reg : col_reg + 1'b1);

    scr_raw_store #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_raw_store (
        .clk   (clk),
        .we    (state_reg == ST_SCALE),
        .waddr (col_reg),
        .wdata (raw_units),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    always_comb
    begin
        if (col_reg == '0)
        begin
            smooth_sum = (UNITS_W+2)'(win_b_reg) * 3'd3 + (UNITS_W+2)'(win_c_reg);
        end
        else if (col_last)
        begin
            smooth_sum = (UNITS_W+2)'(win_a_reg) + (UNITS_W+2)'(win_b_reg) * 3'd3;
        end
        else
        begin
            smooth_sum = (UNITS_W+2)'(win_a_reg) + ((UNITS_W+2)'(win_b_reg) << 1)
                         + (UNITS_W+2)'(win_c_reg);
        end
    end

    assign out_free = !out_valid_reg || column.ready;
    assign out_load = (state_reg == ST_SOUT) && out_free;

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (item.operation == OP_RENDER) && render_ok)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (setup_cnt_reg == '0)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_READ;
            ST_READ:  state_next = ST_MAC;
            ST_MAC:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = col_last ? ST_SPRE : ST_READ;
            ST_SPRE:  state_next = ST_SRD;
            ST_SRD:   state_next = ST_SCAP;
            ST_SCAP:  state_next = ST_SOUT;
            ST_SOUT:
            begin
                if (out_free)
                begin
                    state_next = col_last ? ST_IDLE : ST_SRD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (column.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    elapsed_reg   <= item.elapsed_ms;
                    active_reg    <= active_in;
                    den_reg       <= DEN_W'(w_m1);
                    last_col_reg  <= CAW'(w_m1);
                    rows_reg      <= rows_eff;
                    setup_cnt_reg <= SETUP_CNT_W'(ELAPSED_W - 1);
                    decay_reg     <= '0;
                    rem_b_reg     <= '0;
                    quot_b_reg    <= '0;
                end
            end
            ST_SETUP:
            begin
                setup_cnt_reg <= setup_cnt_reg - 1'b1;
                decay_reg     <= decay_prod[DECAY_SHIFT +: DECAY_W];
                rem_b_reg     <= DEN_W'(ge_b ? sh_b - {1'b0, den_reg} : sh_b);
                quot_b_reg    <= BAW'({quot_b_reg, ge_b});
            end
            ST_PREP:
            begin
                sub_reg  <= SUB_W'(decay_reg) * DECAY_STEP;
                col_reg  <= '0;
                left_reg <= '0;
                r_reg    <= '0;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    p_reg <= p_next;
                end
            end
            ST_SCALE:
            begin
                r_reg    <= DEN_W'(r_wrap ? r_sum - {1'b0, den_reg} : r_sum);
                left_reg <= left_reg + quot_b_reg + BAW'(r_wrap);
                col_reg  <= col_last ? '0 : col_reg + 1'b1;
            end
            ST_SRD:
            begin
                if (col_reg == '0)
                begin
                    win_b_reg <= raw_rdata;
                end
            end
            ST_SCAP:
            begin
                win_c_reg <= raw_rdata;
            end
            ST_SOUT:
            begin
                if (out_free)
                begin
                    out_col_reg   <= COL_IDX_W'(col_reg);
                    out_units_reg <= smooth_sum[UNITS_W+1:2];
                    out_last_reg  <= col_last;
                    win_a_reg     <= win_b_reg;
                    win_b_reg     <= win_c_reg;
                    col_reg       <= col_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign column.valid        = out_valid_reg;
    assign column.column_index = out_col_reg;
    assign column.bar_units    = out_units_reg;
    assign column.last_column  = out_last_reg;

endmodule
